// ===== sv/priority_sum_tree_assert.svh =====
// Assertion macros for the priority sum tree.
// Used at the end of the top level; needs clk and rst in scope.
`ifndef PRIORITY_SUM_TREE_ASSERT_SVH
`define PRIORITY_SUM_TREE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pst_pkg.sv =====
// Package for the priority sum tree: sizes, widths and operation codes.
// Has no dependencies.
`timescale 1ns / 1ps

package pst_pkg;

  localparam int CAPACITY      = 1024;
  localparam int PRIORITY_BITS = 32;

  localparam int NODE_COUNT = 2 * CAPACITY - 1;
  localparam int LEAF_BASE  = CAPACITY - 1;
  localparam int NODE_AW    = $clog2(NODE_COUNT);

  localparam int FUNC_W  = 2;
  localparam int SLOT_W  = 10;
  localparam int PRIO_W  = 32;
  localparam int SUM_W   = 42;
  localparam int COUNT_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;

endpackage

// ===== sv/priority_sum_tree.sv =====
// Priority sum tree with all node sums held in one synchronous memory.
// Depends on pst_pkg and the macros in priority_sum_tree_assert.svh.
// Each request makes one memory access per tree level, for all functions.
// The next request is taken only once the last has moved to the result register.
// Reset: a clearing pass zeroes all 2047 nodes, one per cycle, before the first request.
// The result register lets a new request be accepted while a result waits.
`timescale 1ns / 1ps

module priority_sum_tree (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pst_pkg::FUNC_W-1:0]   func,
  input  logic [pst_pkg::SLOT_W-1:0]   slot_index,
  input  logic [pst_pkg::PRIO_W-1:0]   priority_req,
  input  logic [pst_pkg::SUM_W-1:0]    target_sum,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pst_pkg::SLOT_W-1:0]   result_slot,
  output logic [pst_pkg::PRIO_W-1:0]   slot_priority,
  output logic [pst_pkg::SUM_W-1:0]    total_sum,
  output logic [pst_pkg::COUNT_W-1:0]  stored_count
);
  import pst_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_UP,
    ST_DOWN,
    ST_FINAL,
    ST_DONE
  } state_t;

  state_t               state;
  logic [NODE_AW-1:0]   clr_addr;
  logic [NODE_AW-1:0]   node;
  logic [SUM_W-1:0]     prio_q;
  logic [SUM_W-1:0]     delta;
  logic [SUM_W-1:0]     remain;
  logic [SUM_W-1:0]     leaf_val;
  logic [SUM_W-1:0]     total;
  logic [SLOT_W-1:0]    slot_q;
  logic [SLOT_W-1:0]    write_slot;
  logic [COUNT_W-1:0]   fill_count;

  logic [SUM_W-1:0]     node_mem [NODE_COUNT];
  logic                 mem_we;
  logic [NODE_AW-1:0]   mem_waddr;
  logic [SUM_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [NODE_AW-1:0]   mem_raddr;
  logic [SUM_W-1:0]     mem_rdata;

  logic                 in_take;
  logic                 is_find;
  logic [SLOT_W-1:0]    req_slot;
  logic [NODE_AW-1:0]   req_leaf;
  logic [NODE_AW-1:0]   parent;
  logic [NODE_AW-1:0]   left_node;
  logic                 go_left;
  logic [NODE_AW-1:0]   down_node;
  logic [NODE_AW:0]     down_child;
  logic                 down_is_leaf;
  logic [SUM_W-1:0]     up_sum;
  logic                 out_free;
  logic                 load_out;
  logic                 in_search;
  logic                 root_write;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign is_find  = (func != FUNC_INSERT) && (func != FUNC_UPDATE);
  assign req_slot = (func == FUNC_INSERT) ? write_slot : slot_index;
  assign req_leaf = NODE_AW'(LEAF_BASE) + NODE_AW'(req_slot);

  assign parent       = NODE_AW'((node - 1'b1) >> 1);
  assign left_node    = {node[NODE_AW-2:0], 1'b1};
  assign go_left      = (remain <= mem_rdata);
  assign down_node    = go_left ? left_node : left_node + 1'b1;
  assign down_child   = {down_node, 1'b1};
  assign down_is_leaf = (down_child >= (NODE_AW + 1)'(NODE_COUNT));
  assign up_sum       = mem_rdata + delta;
  assign out_free     = !out_valid || !out_stall;
  assign load_out     = (state == ST_DONE) && out_free;
  assign in_search    = (state == ST_DOWN) || (state == ST_FINAL);
  assign root_write   = (state == ST_UP) && (node == '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node;
    mem_wdata = up_sum;
    mem_re    = 1'b0;
    mem_raddr = parent;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_re    = in_take;
        mem_raddr = is_find ? NODE_AW'(1) : req_leaf;
      end
      ST_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = prio_q;
        mem_re    = 1'b1;
      end
      ST_UP: begin
        mem_we = 1'b1;
        mem_re = (node != '0);
      end
      ST_DOWN: begin
        mem_re    = 1'b1;
        mem_raddr = down_is_leaf ? down_node : down_child[NODE_AW-1:0];
      end
      ST_FINAL, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= node_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      write_slot <= '0;
      fill_count <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == NODE_AW'(NODE_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            prio_q <= SUM_W'(priority_req[PRIORITY_BITS-1:0]);
            remain <= target_sum;
            slot_q <= req_slot;
            if (is_find) begin
              node  <= '0;
              state <= ST_DOWN;
            end else begin
              node  <= req_leaf;
              state <= ST_LEAF;
            end
            if (func == FUNC_INSERT) begin
              write_slot <= (write_slot == SLOT_W'(CAPACITY - 1)) ? '0 : write_slot + 1'b1;
              if (fill_count < COUNT_W'(CAPACITY)) begin
                fill_count <= fill_count + 1'b1;
              end
            end
          end
        end
        ST_LEAF: begin
          delta    <= prio_q - mem_rdata;
          leaf_val <= prio_q;
          node     <= parent;
          state    <= ST_UP;
        end
        ST_UP: begin
          node <= parent;
          if (node == '0) begin
            total <= up_sum;
            state <= ST_DONE;
          end
        end
        ST_DOWN: begin
          node <= down_node;
          if (!go_left) begin
            remain <= remain - mem_rdata;
          end
          if (down_is_leaf) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          leaf_val <= mem_rdata;
          slot_q   <= SLOT_W'(node - NODE_AW'(LEAF_BASE));
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            result_slot   <= slot_q;
            slot_priority <= leaf_val[PRIO_W-1:0];
            total_sum     <= total;
            stored_count  <= fill_count;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "priority_sum_tree_assert.svh"

  `PST_ASSERT_SAME(a_no_write_in_search, in_search, !mem_we, "memory written during a search")
  `PST_ASSERT_SAME(a_count_bound, 1'b1, fill_count <= COUNT_W'(CAPACITY), "fill count too high")
  `PST_ASSERT_NEXT(a_root_total, root_write, total == $past(up_sum), "total not updated")
  `PST_ASSERT_NEXT(a_result_loaded, load_out, out_valid && state == ST_IDLE, "result not loaded")

endmodule

// ===== dv/sum_tree_checker.sv =====
// Checker for the priority sum tree: keeps its own copy of the node sums,
// predicts each result from the accepted requests and compares field by field.
// Depends on pst_pkg for sizes, widths and operation codes.
`timescale 1ns / 1ps

module sum_tree_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [pst_pkg::FUNC_W-1:0]  func,
  input  logic [pst_pkg::SLOT_W-1:0]  slot_index,
  input  logic [pst_pkg::PRIO_W-1:0]  priority_req,
  input  logic [pst_pkg::SUM_W-1:0]   target_sum,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [pst_pkg::SLOT_W-1:0]  result_slot,
  input  logic [pst_pkg::PRIO_W-1:0]  slot_priority,
  input  logic [pst_pkg::SUM_W-1:0]   total_sum,
  input  logic [pst_pkg::COUNT_W-1:0] stored_count,
  output int                          fail_count,
  output int                          awaited
);
  import pst_pkg::*;

  localparam logic [SUM_W-1:0] PRIO_KEEP = (SUM_W'(1) << PRIORITY_BITS) - 1;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [PRIO_W-1:0]  prio;
    logic [SUM_W-1:0]   total;
    logic [COUNT_W-1:0] count;
  } tree_result_t;

  logic [SUM_W-1:0] tree_sums [NODE_COUNT];
  int unsigned      ring_slot;
  int unsigned      filled;
  int               mismatches;
  tree_result_t     awaited_results [$];

  function automatic void write_leaf(int unsigned slot, logic [SUM_W-1:0] prio);
    int unsigned node;
    logic [SUM_W-1:0] delta;
    node = slot + LEAF_BASE;
    delta = prio - tree_sums[node];
    tree_sums[node] = prio;
    while (node > 0) begin
      node = (node - 1) / 2;
      tree_sums[node] = tree_sums[node] + delta;
    end
  endfunction

  function automatic int unsigned locate_slot(logic [SUM_W-1:0] target);
    int unsigned node;
    logic [SUM_W-1:0] rest;
    node = 0;
    rest = target;
    while (2 * node + 1 < NODE_COUNT) begin
      if (rest <= tree_sums[2 * node + 1]) begin
        node = 2 * node + 1;
      end else begin
        rest = rest - tree_sums[2 * node + 1];
        node = 2 * node + 2;
      end
    end
    return node - LEAF_BASE;
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    int unsigned slot;
    logic [SUM_W-1:0] prio_in;
    tree_result_t want;
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        tree_sums[i] = '0;
      end
      ring_slot = 0;
      filled = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: slot 0x%0h", result_slot);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("result_slot", want.slot, result_slot);
          compare_field("slot_priority", want.prio, slot_priority);
          compare_field("total_sum", want.total, total_sum);
          compare_field("stored_count", want.count, stored_count);
        end
      end
      if (in_valid && !in_stall) begin
        prio_in = SUM_W'(priority_req) & PRIO_KEEP;
        case (func)
          FUNC_INSERT: begin
            slot = ring_slot;
            write_leaf(slot, prio_in);
            ring_slot = (ring_slot + 1) % CAPACITY;
            if (filled < CAPACITY) begin
              filled++;
            end
          end
          FUNC_UPDATE: begin
            slot = slot_index % CAPACITY;
            write_leaf(slot, prio_in);
          end
          default: begin
            slot = locate_slot(target_sum);
          end
        endcase
        want.slot  = SLOT_W'(slot);
        want.prio  = tree_sums[slot + LEAF_BASE][PRIO_W-1:0];
        want.total = tree_sums[0];
        want.count = COUNT_W'(filled);
        awaited_results.push_back(want);
      end
    end
    fail_count <= mismatches;
    awaited <= awaited_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the priority sum tree testbench: clock, reset, request stimulus with
// random gaps and result stalls, and the final verdict.
// Depends on pst_pkg, priority_sum_tree and sum_tree_checker.
`timescale 1ns / 1ps

module testbench;
  import pst_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_FIND       = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIND_ALIAS = 2'd3;
  localparam int RANDOM_ITEMS = 1060;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  func = FUNC_FIND;
  logic [SLOT_W-1:0]  slot_index = '0;
  logic [PRIO_W-1:0]  priority_req = '0;
  logic [SUM_W-1:0]   target_sum = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SLOT_W-1:0]  result_slot;
  logic [PRIO_W-1:0]  slot_priority;
  logic [SUM_W-1:0]   total_sum;
  logic [COUNT_W-1:0] stored_count;
  int                 fail_count;
  int                 awaited;

  logic [SUM_W-1:0] seen_total = '0;
  bit               calm = 1'b0;
  int               inserts_sent = 0;

  priority_sum_tree i_dut (.*);

  sum_tree_checker i_checker (.*);

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      seen_total <= total_sum;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(16, 60);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return $urandom;
    end else if (r < 75) begin
      return $urandom_range(0, 65535);
    end else if (r < 85) begin
      return '0;
    end else if (r < 92) begin
      return '1;
    end
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [SUM_W-1:0] pick_target();
    logic [63:0] wide;
    int r;
    wide = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return SUM_W'(wide % (64'(seen_total) + 64'd1));
    end else if (r < 78) begin
      return seen_total;
    end else if (r < 84) begin
      return seen_total + 1'b1;
    end else if (r < 90) begin
      return '0;
    end else if (r < 95) begin
      return '1;
    end
    return wide[SUM_W-1:0];
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                              input logic [PRIO_W-1:0] p, input logic [SUM_W-1:0] t);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    slot_index <= s;
    priority_req <= p;
    target_sum <= t;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (f == FUNC_INSERT) begin
      inserts_sent++;
    end
  endtask

  initial begin
    int n;
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int r;
    logic [FUNC_W-1:0] f;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Searches on the empty tree, then a small tree with exact ties at the boundaries, then updates and more searches.
    send_request(FUNC_FIND, '0, '0, '0);
    send_request(FUNC_FIND_ALIAS, '1, '1, '1);
    send_request(FUNC_INSERT, '0, 32'h0001_0000, '0);
    send_request(FUNC_INSERT, '1, 32'h0002_0000, '1);
    send_request(FUNC_INSERT, 10'h155, '0, 42'h2AA_AAAA_AAAA);
    send_request(FUNC_INSERT, 10'h2AA, '1, 42'h155_5555_5555);
    send_request(FUNC_FIND, '0, '0, 42'h0_0001_0000);
    send_request(FUNC_FIND, '0, '0, 42'h0_0001_0001);
    send_request(FUNC_FIND, '0, '0, 42'h0_0003_0000);
    send_request(FUNC_FIND, '0, '0, 42'h0_0003_0001);
    send_request(FUNC_FIND, '0, '0, 42'h1_0002_FFFF);
    send_request(FUNC_FIND, '0, '0, 42'h1_0003_0000);
    send_request(FUNC_FIND_ALIAS, '0, '0, '1);
    send_request(FUNC_UPDATE, '1, '1, '0);
    send_request(FUNC_UPDATE, '0, '0, '1);
    send_request(FUNC_UPDATE, 10'd3, 32'h0000_0001, '0);
    send_request(FUNC_UPDATE, 10'd512, 32'hAAAA_AAAA, '0);
    send_request(FUNC_UPDATE, 10'h155, 32'h5555_5555, '0);
    send_request(FUNC_FIND_ALIAS, '0, '0, 42'h2AA_AAAA_AAAA);
    send_request(FUNC_FIND, '0, '0, 42'h155_5555_5555);
    send_request(FUNC_FIND, '0, '0, '0);
    send_request(FUNC_UPDATE, '1, '0, '0);
    send_request(FUNC_FIND, '1, '1, '1);

    // Mostly inserts, so that the ring wraps and the count saturates.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 83 || inserts_sent + (RANDOM_ITEMS - k) <= CAPACITY + 8) begin
        f = FUNC_INSERT;
      end else if (r < 90) begin
        f = FUNC_UPDATE;
      end else if (r < 98) begin
        f = FUNC_FIND;
      end else begin
        f = FUNC_FIND_ALIAS;
      end
      send_request(f, SLOT_W'($urandom), pick_priority(), pick_target());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
